FILE: rtl/jse_pkg.sv
// Shared types, codes and escape helper functions for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

   // Decision codes from the sequence classifier
   localparam logic [1:0] ACT_DONE = 2'd0;  // nothing left in the buffer
   localparam logic [1:0] ACT_ESC  = 2'd1;  // escape the head byte alone
   localparam logic [1:0] ACT_RAW  = 2'd2;  // copy a complete sequence raw
   localparam logic [1:0] ACT_HOLD = 2'd3;  // keep the partial sequence for later

   // Characters used in escapes
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] need;    // sequence length for a raw copy
   } jse_decision_type;

   // Lower-case hex digit
   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = CH_ZERO + {4'h0, n};
      end else begin
         r = 8'h57 + {4'h0, n};
      end
      return r;
   endfunction

   // Number of output bytes for one escaped byte: 1, 2 or 6
   function automatic logic [2:0] esc_len(input logic [7:0] b);
      logic [2:0] r;
      if (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF || b == CH_CR || b == CH_TAB) begin
         r = 3'd2;
      end else if (b < 8'h20 || b >= 8'h80) begin
         r = 3'd6;
      end else begin
         r = 3'd1;
      end
      return r;
   endfunction

   // Byte k of the escape for b
   function automatic logic [7:0] esc_byte(input logic [7:0] b, input logic [2:0] k);
      logic [7:0] r;
      r = b;
      if (esc_len(b) == 3'd2) begin
         if (k == 3'd0) begin
            r = CH_BSLASH;
         end else begin
            case (b)
               CH_QUOTE:  r = CH_QUOTE;
               CH_BSLASH: r = CH_BSLASH;
               CH_LF:     r = CH_N;
               CH_CR:     r = CH_R;
               default:   r = CH_T;
            endcase
         end
      end else if (esc_len(b) == 3'd6) begin
         case (k)
            3'd0:    r = CH_BSLASH;
            3'd1:    r = CH_U;
            3'd2:    r = CH_ZERO;
            3'd3:    r = CH_ZERO;
            3'd4:    r = hex_digit(b[7:4]);
            default: r = hex_digit(b[3:0]);
         endcase
      end
      return r;
   endfunction

endpackage

FILE: rtl/jse_chan_if.sv
// Valid/ready channel interfaces for the escaper's byte input and byte output.
`timescale 1ns / 1ps

interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/jse_classify.sv
// Strict UTF-8 classifier for the head of the byte buffer.
`timescale 1ns / 1ps

module jse_classify (
   input  logic [7:0]                b0,
   input  logic [7:0]                b1,
   input  logic [7:0]                b2,
   input  logic [7:0]                b3,
   input  logic [2:0]                count,
   input  logic                      last,
   output jse_pkg::jse_decision_type decision
);

   logic [2:0] need;
   logic [2:0] lim;
   logic       second_ok;
   logic       bad;

   // Sequence length from the lead byte
   always_comb begin
      if (b0 inside {[8'hc2:8'hdf]}) begin
         need = 3'd2;
      end else if (b0 inside {[8'he0:8'hef]}) begin
         need = 3'd3;
      end else if (b0 inside {[8'hf0:8'hf4]}) begin
         need = 3'd4;
      end else begin
         need = 3'd0;
      end
   end

   // Strict second-byte ranges
   always_comb begin
      case (b0)
         8'he0:   second_ok = b1 inside {[8'ha0:8'hbf]};
         8'hed:   second_ok = b1 inside {[8'h80:8'h9f]};
         8'hf0:   second_ok = b1 inside {[8'h90:8'hbf]};
         8'hf4:   second_ok = b1 inside {[8'h80:8'h8f]};
         default: second_ok = b1 inside {[8'h80:8'hbf]};
      endcase
   end

   // Only the bytes present so far are checked
   assign lim = (count < need) ? count : need;
   assign bad = (lim >= 3'd2 && !second_ok)
             || (lim >= 3'd3 && !(b2 inside {[8'h80:8'hbf]}))
             || (lim >= 3'd4 && !(b3 inside {[8'h80:8'hbf]}));

   always_comb begin
      decision.need = need;
      if (count == 3'd0) begin
         decision.action = jse_pkg::ACT_DONE;
      end else if (need == 3'd0 || bad) begin
         decision.action = jse_pkg::ACT_ESC;
      end else if (count >= need) begin
         decision.action = jse_pkg::ACT_RAW;
      end else if (last) begin
         decision.action = jse_pkg::ACT_ESC;
      end else begin
         decision.action = jse_pkg::ACT_HOLD;
      end
   end

endmodule

FILE: rtl/json_string_escaper_utf8_core.sv
// Top level of the JSON string escaper with strict UTF-8 pass-through.
// Usage:
//   req_chan carries one string byte per word (in_byte) and in_last on the
//   final byte of a string. rsp_chan carries the escaped text one byte per
//   word; out_last marks the final output byte of a string.
//   Well-formed UTF-8 sequences pass raw; a lead byte whose sequence is not
//   complete yet is kept (up to three bytes) until the next word arrives.
//   Broken sequences, or a string that ends mid-sequence, get the lead byte
//   escaped as \u00xx and the remaining bytes are examined again.
// Operation:
//   An input word is taken while idle, then a shared classify/emit
//   sequencer runs: a decision on the buffer head, then the output bytes of
//   that decision, repeated until the buffer is empty or holds a partial
//   sequence. In the worst case four bytes are replayed as escapes.
//   req_chan.ready is high only while idle.
// Reset (synchronous, active high) drops any held bytes and the pending
// output word. A stall on rsp_chan holds the output register and freezes
// the sequencer; the input stays blocked until the item is fully emitted.
`timescale 1ns / 1ps

module json_string_escaper_utf8_core (
   input  logic            clock,
   input  logic            reset,
   jse_req_if.sink         req_chan,
   jse_rsp_if.source       rsp_chan
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_ESC    = 2'd2;
   localparam logic [1:0] ST_RAW    = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [7:0] buf_ff [4];
   logic [7:0] buf_in [4];
   logic [2:0] count_ff, count_in;
   logic       last_ff, last_in;
   logic [2:0] k_ff, k_in;
   logic [2:0] raw_left_ff, raw_left_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   jse_pkg::jse_decision_type decision;
   logic       slot_free;
   logic       accept;
   logic [2:0] head_len;

   jse_classify u_classify (
      .b0       (buf_ff[0]),
      .b1       (buf_ff[1]),
      .b2       (buf_ff[2]),
      .b3       (buf_ff[3]),
      .count    (count_ff),
      .last     (last_ff),
      .decision (decision)
   );

   assign slot_free        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign head_len         = jse_pkg::esc_len(buf_ff[0]);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.out_last = rsp_last_ff;

   // Sequencer: append, classify head, emit escape or raw bytes
   always_comb begin
      state_in    = state_ff;
      buf_in      = buf_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      k_in        = k_ff;
      raw_left_in = raw_left_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               buf_in[count_ff[1:0]] = req_chan.in_byte;
               count_in = count_ff + 3'd1;
               last_in  = req_chan.in_last;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (decision.action)
               jse_pkg::ACT_ESC: begin
                  k_in     = 3'd0;
                  state_in = ST_ESC;
               end
               jse_pkg::ACT_RAW: begin
                  raw_left_in = decision.need;
                  state_in    = ST_RAW;
               end
               default: begin
                  // done, or partial sequence kept at the buffer head
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_ESC: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = jse_pkg::esc_byte(buf_ff[0], k_ff);
               rsp_last_in  = 1'b0;
               if (k_ff == head_len - 3'd1) begin
                  rsp_last_in = last_ff && (count_ff == 3'd1);
                  buf_in[0] = buf_ff[1];
                  buf_in[1] = buf_ff[2];
                  buf_in[2] = buf_ff[3];
                  count_in  = count_ff - 3'd1;
                  state_in  = ST_DECIDE;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end
         default: begin
            // ST_RAW: copy the sequence one byte at a time
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = buf_ff[0];
               rsp_last_in  = last_ff && (count_ff == 3'd1);
               buf_in[0]    = buf_ff[1];
               buf_in[1]    = buf_ff[2];
               buf_in[2]    = buf_ff[3];
               count_in     = count_ff - 3'd1;
               raw_left_in  = raw_left_ff - 3'd1;
               if (raw_left_ff == 3'd1) begin
                  state_in = ST_DECIDE;
               end
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      raw_left_ff <= raw_left_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

FILE: tb/jse_checker.sv
// Checker for the JSON string escaper: predicts the escaped text and compares every output word.
`timescale 1ns / 1ps

module jse_checker (
   input  logic        clock,
   input  logic        reset,
   jse_req_if          req_chan,
   jse_rsp_if          rsp_chan,
   output int unsigned fail_count,
   output int unsigned outstanding,
   output int unsigned bytes_checked
);

   // Expected escaped text, one entry per output word
   logic [7:0]  exp_text [$];
   logic        exp_last [$];
   // Text produced by the word being predicted
   logic [7:0]  step_text [$];

   // Pending lead byte and its continuations
   logic [7:0]  held_buf [0:2];
   int unsigned held_num;

   int unsigned errors;
   int unsigned checked;
   logic [7:0]  want_byte;
   logic        want_last;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + {4'h0, n};
      end
      return 8'h61 + {4'h0, n} - 8'd10;
   endfunction

   // Full length of a UTF-8 sequence from its lead; 0 means not a lead
   function automatic int unsigned lead_seq_len(input logic [7:0] lead);
      if (lead >= 8'hc2 && lead <= 8'hdf) return 2;
      if (lead >= 8'he0 && lead <= 8'hef) return 3;
      if (lead >= 8'hf0 && lead <= 8'hf4) return 4;
      return 0;
   endfunction

   // Strict range of the byte after the lead
   function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
      case (lead)
         8'he0:   return b >= 8'ha0 && b <= 8'hbf;
         8'hed:   return b >= 8'h80 && b <= 8'h9f;
         8'hf0:   return b >= 8'h90 && b <= 8'hbf;
         8'hf4:   return b >= 8'h80 && b <= 8'h8f;
         default: return b >= 8'h80 && b <= 8'hbf;
      endcase
   endfunction

   // JSON escape of one byte on its own
   task automatic escape_byte(input logic [7:0] b);
      case (b)
         jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH: begin
            step_text.push_back(jse_pkg::CH_BSLASH);
            step_text.push_back(b);
         end
         jse_pkg::CH_LF: begin
            step_text.push_back(jse_pkg::CH_BSLASH);
            step_text.push_back(jse_pkg::CH_N);
         end
         jse_pkg::CH_CR: begin
            step_text.push_back(jse_pkg::CH_BSLASH);
            step_text.push_back(jse_pkg::CH_R);
         end
         jse_pkg::CH_TAB: begin
            step_text.push_back(jse_pkg::CH_BSLASH);
            step_text.push_back(jse_pkg::CH_T);
         end
         default: begin
            if (b < 8'h20 || b >= 8'h80) begin
               step_text.push_back(jse_pkg::CH_BSLASH);
               step_text.push_back(jse_pkg::CH_U);
               step_text.push_back(jse_pkg::CH_ZERO);
               step_text.push_back(jse_pkg::CH_ZERO);
               step_text.push_back(hex_char(b[7:4]));
               step_text.push_back(hex_char(b[3:0]));
            end else begin
               step_text.push_back(b);
            end
         end
      endcase
   endtask

   // Work out the text caused by one accepted input word
   task automatic predict_word(input logic [7:0] b, input logic lst);
      logic [7:0]  work [0:3];
      logic [7:0]  lead;
      int unsigned n, pos, need, avail, lim, j, k;
      logic        bad, stop;
      n = held_num;
      for (j = 0; j < n; j++) work[j] = held_buf[j];
      work[n] = b;
      n = n + 1;
      held_num = 0;
      pos = 0;
      stop = 1'b0;
      step_text.delete();
      while (pos < n && !stop) begin
         lead = work[pos];
         need = lead_seq_len(lead);
         avail = n - pos;
         if (need == 0) begin
            escape_byte(lead);
            pos = pos + 1;
         end else begin
            lim = (avail < need) ? avail : need;
            bad = 1'b0;
            for (j = 1; j < lim; j++) begin
               if (!bad) begin
                  if (j == 1) bad = !second_fits(lead, work[pos + j]);
                  else bad = !(work[pos + j] >= 8'h80 && work[pos + j] <= 8'hbf);
               end
            end
            if (bad || (avail < need && lst)) begin
               // broken or cut short: escape the lead, look again at the rest
               escape_byte(lead);
               pos = pos + 1;
            end else if (avail >= need) begin
               for (j = 0; j < need; j++) step_text.push_back(work[pos + j]);
               pos = pos + need;
            end else begin
               // viable but incomplete: keep the tail for the next word
               for (j = 0; j < avail; j++) held_buf[j] = work[pos + j];
               held_num = avail;
               stop = 1'b1;
            end
         end
      end
      for (k = 0; k < step_text.size(); k++) begin
         exp_text.push_back(step_text[k]);
         exp_last.push_back(lst && (k == step_text.size() - 1));
      end
   endtask

   // Output words are checked before the input word of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         held_num = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (exp_text.size() == 0) begin
               errors++;
               $error("output word with no expected byte: out_byte=%h out_last=%b",
                      rsp_chan.out_byte, rsp_chan.out_last);
            end else begin
               want_byte = exp_text.pop_front();
               want_last = exp_last.pop_front();
               checked++;
               if (rsp_chan.out_byte !== want_byte) begin
                  errors++;
                  $error("out_byte mismatch: expected %h, actual %h",
                         want_byte, rsp_chan.out_byte);
               end
               if (rsp_chan.out_last !== want_last) begin
                  errors++;
                  $error("out_last mismatch: expected %b, actual %b",
                         want_last, rsp_chan.out_last);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_word(req_chan.in_byte, req_chan.in_last);
         end
      end
      fail_count    <= errors;
      outstanding   <= exp_text.size();
      bytes_checked <= checked;
   end

endmodule

FILE: tb/testbench.sv
// Top of the escaper testbench: clock, reset, string stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned WORDS_PER_PHASE = 95;
   localparam int unsigned TAIL_CYCLES = 40;

   logic        clock;
   logic        reset;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned words_sent;
   int unsigned strings_sent;
   int unsigned quiet_cycles;
   int unsigned chk_fails;
   int unsigned chk_outstanding;
   int unsigned chk_checked;

   // {in_last, in_byte}: extremes, short escapes, controls, bad leads,
   // shortest and longest sequences, broken ones and a string cut mid-sequence
   logic [8:0] directed_words [0:24] = '{
      9'h041, 9'h022, 9'h05c, 9'h00a, 9'h00d, 9'h009, 9'h000, 9'h01f, 9'h07f,
      9'h080, 9'h0ff, 9'h0c2, 9'h080, 9'h0f4, 9'h08f, 9'h0bf, 9'h0bf, 9'h0e0,
      9'h09f, 9'h0f0, 9'h090, 9'h180, 9'h0ed, 9'h0a0, 9'h17e
   };
   logic [7:0] short_escapes [0:4] = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH,
                                       jse_pkg::CH_LF, jse_pkg::CH_CR, jse_pkg::CH_TAB};
   logic [7:0] string_bytes [$];

   jse_req_if req_chan ();
   jse_rsp_if rsp_chan ();

   json_string_escaper_utf8_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   jse_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (chk_fails),
      .outstanding   (chk_outstanding),
      .bytes_checked (chk_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one word, with a random gap first, and wait until it is taken
   task automatic send_word(input logic [7:0] b, input logic lst);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= lst;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   // Hold off the sender until every expected byte has come out
   task automatic drain_output();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (chk_outstanding != 0) @(posedge clock);
   endtask

   // Append one well-formed UTF-8 sequence with random content
   task automatic push_utf8_seq(output int unsigned len);
      logic [7:0] lead, second;
      case ($urandom_range(0, 6))
         0: begin
            lead = 8'($urandom_range(8'hc2, 8'hdf));
            second = 8'($urandom_range(8'h80, 8'hbf));
            len = 2;
         end
         1: begin
            lead = 8'he0;
            second = 8'($urandom_range(8'ha0, 8'hbf));
            len = 3;
         end
         2: begin
            do lead = 8'($urandom_range(8'he1, 8'hef)); while (lead == 8'hed);
            second = 8'($urandom_range(8'h80, 8'hbf));
            len = 3;
         end
         3: begin
            lead = 8'hed;
            second = 8'($urandom_range(8'h80, 8'h9f));
            len = 3;
         end
         4: begin
            lead = 8'hf0;
            second = 8'($urandom_range(8'h90, 8'hbf));
            len = 4;
         end
         5: begin
            lead = 8'($urandom_range(8'hf1, 8'hf3));
            second = 8'($urandom_range(8'h80, 8'hbf));
            len = 4;
         end
         default: begin
            lead = 8'hf4;
            second = 8'($urandom_range(8'h80, 8'h8f));
            len = 4;
         end
      endcase
      string_bytes.push_back(lead);
      string_bytes.push_back(second);
      repeat (len - 2) string_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
   endtask

   // One random string: mostly text and good sequences, some broken or cut ones and noise
   task automatic send_random_string();
      int unsigned nchars, r, len, idx, k;
      string_bytes.delete();
      nchars = $urandom_range(1, 10);
      repeat (nchars) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            string_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
         end else if (r < 40) begin
            string_bytes.push_back(short_escapes[$urandom_range(0, 4)]);
         end else if (r < 48) begin
            string_bytes.push_back(8'($urandom_range(8'h00, 8'h1f)));
         end else if (r < 78) begin
            push_utf8_seq(len);
         end else if (r < 86) begin
            // corrupt one byte after the lead
            push_utf8_seq(len);
            idx = string_bytes.size() - len + $urandom_range(1, len - 1);
            string_bytes[idx] = 8'($urandom_range(0, 255));
         end else if (r < 92) begin
            // drop the tail of a sequence
            push_utf8_seq(len);
            repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
         end else begin
            string_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (k = 0; k < string_bytes.size(); k++) begin
         send_word(string_bytes[k], k == string_bytes.size() - 1);
      end
      strings_sent++;
   endtask

   initial begin
      int phase;
      int i;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.in_last = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      words_sent       = 0;
      strings_sent     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         // no idling, sender gaps, receiver stalls, then both
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 87; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 87; end
            default: begin idle_pct = 35; stall_pct <= 35; end
         endcase
         if (phase == 0) begin
            for (i = 0; i < 25; i++) begin
               send_word(directed_words[i][7:0], directed_words[i][8]);
            end
         end
         while (words_sent < (phase + 1) * WORDS_PER_PHASE) send_random_string();
         drain_output();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d input words in %0d strings; %0d escaped output words checked",
               words_sent, strings_sent, chk_checked);
      $display("Phases: free flow, sender gaps, receiver stalls, mixed; drained between each");
      if (chk_fails == 0 && chk_outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
